// ===== sv/itp_pkg.sv =====
// Shared types and constants for the infix to postfix token converter.
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 32;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_FUNC_PRIO   = 2'd0;
  localparam logic [1:0] REG_OPEN_PAREN  = 2'd1;
  localparam logic [1:0] REG_CLOSE_PAREN = 2'd2;

  localparam logic [2:0] FUNC_PRIO_RST   = 3'd4;
  localparam logic [7:0] OPEN_PAREN_RST  = 8'd40;
  localparam logic [7:0] CLOSE_PAREN_RST = 8'd41;

  localparam logic [1:0] KIND_OP  = 2'd0;
  localparam logic [1:0] KIND_NUM = 2'd1;
  localparam logic [1:0] KIND_VAR = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  typedef struct packed {
    logic        action;
    logic [7:0]  token_code;
    logic [2:0]  token_priority;
    logic [1:0]  token_kind;
    logic [63:0] payload;
  } tok_t;

  typedef struct packed {
    logic [7:0]  out_code;
    logic [2:0]  out_priority;
    logic [1:0]  out_kind;
    logic [63:0] out_payload;
    logic        overflow_error;
    logic        last;
  } rpn_t;

  typedef struct packed {
    logic [7:0] code;
    logic [2:0] prio;
  } entry_t;

  typedef struct packed {
    logic [2:0] function_priority;
    logic [7:0] open_paren_code;
    logic [7:0] close_paren_code;
  } cfg_t;

  typedef enum logic [1:0] {
    SEL_TOS,
    SEL_TOKEN,
    SEL_ERROR,
    SEL_END
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      push;
    logic      pop;
    logic      emit;
    emit_sel_t sel;
    logic      last;
  } dp_cmd_t;

  typedef struct packed {
    logic is_end;
    logic is_operand;
    logic is_pushed;
    logic is_close;
    logic empty;
    logic full;
    logic cnt_one;
    logic tos_open;
    logic below_open;
    logic tos_pops;
    logic below_pops;
    logic out_free;
  } dp_status_t;

endpackage

// ===== sv/itp_cfg.sv =====
// APB register block holding the converter configuration.
module itp_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [itp_pkg::PADDR_W-1:0]  paddr,
  input  logic [itp_pkg::PDATA_W-1:0]  pwdata,
  output logic [itp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output itp_pkg::cfg_t                cfg
);
  import itp_pkg::*;

  logic [1:0] index;
  logic       wr;

  assign pready = 1'b1;
  assign index  = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.function_priority <= FUNC_PRIO_RST;
      cfg.open_paren_code   <= OPEN_PAREN_RST;
      cfg.close_paren_code  <= CLOSE_PAREN_RST;
    end else if (wr) begin
      case (index)
        REG_FUNC_PRIO:   cfg.function_priority <= pwdata[2:0];
        REG_OPEN_PAREN:  cfg.open_paren_code   <= pwdata[7:0];
        REG_CLOSE_PAREN: cfg.close_paren_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_FUNC_PRIO:   prdata = {{(PDATA_W-3){1'b0}}, cfg.function_priority};
      REG_OPEN_PAREN:  prdata = {{(PDATA_W-8){1'b0}}, cfg.open_paren_code};
      REG_CLOSE_PAREN: prdata = {{(PDATA_W-8){1'b0}}, cfg.close_paren_code};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== sv/itp_dp.sv =====
// Datapath: token register, operator stack with cached top, output register.
module itp_dp #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  itp_pkg::tok_t       tok,
  input  itp_pkg::cfg_t       cfg,
  input  itp_pkg::dp_cmd_t    cmd,
  output itp_pkg::dp_status_t status,
  output logic                rpn_valid,
  input  logic                rpn_ready,
  output itp_pkg::rpn_t       rpn
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  // top of stack lives in tos; mem holds the entries below it
  entry_t        mem [STACK_DEPTH-1];
  tok_t          item;
  entry_t        tos;
  entry_t        below;
  entry_t        new_entry;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_next_m2;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic          wen;
  rpn_t          rpn_next;

  assign new_entry.code = item.token_code;
  assign new_entry.prio = item.token_priority;

  always_comb begin
    if (cmd.push) begin
      count_next = count + CW'(1);
    end else if (cmd.pop) begin
      count_next = count - CW'(1);
    end else begin
      count_next = count;
    end
  end

  assign count_m1      = count - CW'(1);
  assign count_next_m2 = count_next - CW'(2);
  assign waddr         = count_m1[AW-1:0];
  assign raddr         = count_next_m2[AW-1:0];
  assign wen           = cmd.push && (count != '0);

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= tos;
    end
    if (wen && (waddr == raddr)) begin
      below <= tos;
    end else begin
      below <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= tok;
    end
    if (cmd.push) begin
      tos <= new_entry;
    end else if (cmd.pop) begin
      tos <= below;
    end
    if (cmd.emit) begin
      rpn <= rpn_next;
    end
    if (rst) begin
      count     <= '0;
      rpn_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (cmd.emit) begin
        rpn_valid <= 1'b1;
      end else if (rpn_ready) begin
        rpn_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    rpn_next = '0;
    rpn_next.last = cmd.last;
    case (cmd.sel)
      SEL_TOS: begin
        rpn_next.out_code     = tos.code;
        rpn_next.out_priority = tos.prio;
        rpn_next.out_kind     = KIND_OP;
      end
      SEL_TOKEN: begin
        rpn_next.out_code     = item.token_code;
        rpn_next.out_priority = item.token_priority;
        rpn_next.out_kind     = item.token_kind;
        rpn_next.out_payload  = item.payload;
      end
      SEL_ERROR: begin
        rpn_next.out_code       = item.token_code;
        rpn_next.out_priority   = item.token_priority;
        rpn_next.out_kind       = KIND_OP;
        rpn_next.overflow_error = 1'b1;
      end
      SEL_END: begin
        rpn_next.out_kind = KIND_END;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.is_end     = item.action;
    status.is_operand = (item.token_kind == KIND_NUM) || (item.token_kind == KIND_VAR);
    status.is_pushed  = (item.token_priority == cfg.function_priority) ||
                        (item.token_code == cfg.open_paren_code);
    status.is_close   = item.token_code == cfg.close_paren_code;
    status.empty      = count == '0;
    status.full       = count == DEPTH_C;
    status.cnt_one    = count == CW'(1);
    status.tos_open   = tos.code == cfg.open_paren_code;
    status.below_open = below.code == cfg.open_paren_code;
    status.tos_pops   = item.token_priority <= tos.prio;
    status.below_pops = item.token_priority <= below.prio;
    status.out_free   = !rpn_valid || rpn_ready;
  end

endmodule

// ===== sv/itp_ctrl.sv =====
// Controller: sequences accept, pops, pushes and emits for one token.
module itp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                tok_valid,
  output logic                tok_ready,
  input  itp_pkg::dp_status_t st,
  output itp_pkg::dp_cmd_t    cmd
);
  import itp_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t state;
  logic   done;

  assign tok_ready = state == S_IDLE;

  always_comb begin
    cmd      = '0;
    cmd.sel  = SEL_TOS;
    done     = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.load = tok_valid;
      end
      S_RUN: begin
        if (st.out_free) begin
          if (st.is_end) begin
            if (!st.empty) begin
              cmd.emit = 1'b1;
              cmd.pop  = 1'b1;
            end else begin
              cmd.emit = 1'b1;
              cmd.sel  = SEL_END;
              cmd.last = 1'b1;
              done     = 1'b1;
            end
          end else if (st.is_operand) begin
            cmd.emit = 1'b1;
            cmd.sel  = SEL_TOKEN;
            cmd.last = 1'b1;
            done     = 1'b1;
          end else if (st.is_pushed) begin
            if (st.full) begin
              cmd.emit = 1'b1;
              cmd.sel  = SEL_ERROR;
              cmd.last = 1'b1;
            end else begin
              cmd.push = 1'b1;
            end
            done = 1'b1;
          end else if (st.is_close) begin
            if (!st.empty && !st.tos_open) begin
              cmd.emit = 1'b1;
              cmd.pop  = 1'b1;
              cmd.last = st.cnt_one || st.below_open;
            end else begin
              cmd.pop = !st.empty;
              done    = 1'b1;
            end
          end else begin
            if (!st.empty && !st.tos_open && st.tos_pops) begin
              // push after the final pop always fits, so that pop ends the item
              cmd.emit = 1'b1;
              cmd.pop  = 1'b1;
              cmd.last = st.cnt_one || st.below_open || !st.below_pops;
            end else if (st.full) begin
              cmd.emit = 1'b1;
              cmd.sel  = SEL_ERROR;
              cmd.last = 1'b1;
              done     = 1'b1;
            end else begin
              cmd.push = 1'b1;
              done     = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (tok_valid) begin
          state <= S_RUN;
        end
        S_RUN: if (done) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/infix_to_postfix_converter_top.sv =====
// Top level of the shunting-yard infix to postfix token converter.
//
//   channel  direction  handshake             beat
//   tok      in         tok_valid/tok_ready   itp_pkg::tok_t
//   rpn      out        rpn_valid/rpn_ready   itp_pkg::rpn_t
//   apb      in         psel/penable/pready   config registers at 0x0, 0x4, 0x8
//
// One token at a time: accepted in S_IDLE, then its results and stack steps run in S_RUN.
// The pace is one pop per cycle while the output register is free, set by the
// single write and registered read stack memory.
// Reset empties the stack at once (no clearing pass) and loads register defaults.
// A held output register stalls the controller until the beat is taken.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        tok_valid,
  output logic                        tok_ready,
  input  itp_pkg::tok_t               tok,
  output logic                        rpn_valid,
  input  logic                        rpn_ready,
  output itp_pkg::rpn_t               rpn,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [itp_pkg::PADDR_W-1:0] paddr,
  input  logic [itp_pkg::PDATA_W-1:0] pwdata,
  output logic [itp_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import itp_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  itp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  itp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .st        (status),
    .cmd       (cmd)
  );

  itp_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .rpn_valid (rpn_valid),
    .rpn_ready (rpn_ready),
    .rpn       (rpn)
  );

endmodule

// ===== sv/itp_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module itp_checker (
  input logic          clk,
  input logic          rst,
  input logic          tok_valid,
  input logic          tok_ready,
  input logic          rpn_valid,
  input logic          rpn_ready,
  input itp_pkg::rpn_t rpn
);
  import itp_pkg::*;

  a_rpn_hold: assert property (@(posedge clk) disable iff (rst)
    rpn_valid && !rpn_ready |=> rpn_valid && $stable(rpn))
    else $error("rpn beat changed while stalled");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_ready |=> !tok_ready)
    else $error("second token taken while one is in work");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    rpn_valid && (rpn.out_kind == KIND_END) |-> rpn.last && !rpn.overflow_error)
    else $error("end marker not final or flagged as overflow");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    rpn_valid && rpn.overflow_error |->
      rpn.last && (rpn.out_kind == KIND_OP) && (rpn.out_payload == '0))
    else $error("overflow beat malformed");

  a_operand_last: assert property (@(posedge clk) disable iff (rst)
    rpn_valid && ((rpn.out_kind == KIND_NUM) || (rpn.out_kind == KIND_VAR)) |-> rpn.last)
    else $error("operand beat not final");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (tok_valid),
  .tok_ready (tok_ready),
  .rpn_valid (rpn_valid),
  .rpn_ready (rpn_ready),
  .rpn       (rpn)
);
